>>> hdl/aescbc_pkg.sv
package aescbc_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd4;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // inverse of the affine map that follows the field inverse
    function automatic logic [7:0] affine_inv(input logic [7:0] v);
        return {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]} ^ 8'h05;
    endfunction

    function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // field inverse of y is affine_inv(SBOX[y]), so one table serves both ways
    function automatic logic [7:0] sbox_inv(input logic [7:0] b);
        return affine_inv(SBOX[affine_inv(b)]);
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            t[127-8*i -: 8] = inv ? sbox_inv(s[127-8*i -: 8]) : sbox_fwd(s[127-8*i -: 8]);
        end
        return t;
    endfunction

    function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int           o;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o = 4 * ((c + r) & 3) + r;
                if (inv) begin
                    t[127-8*o -: 8] = s[127-8*(4*c+r) -: 8];
                end else begin
                    t[127-8*(4*c+r) -: 8] = s[127-8*o -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] a, input logic inv);
        logic [7:0] x  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m  [4];
        logic [31:0] t;
        t = '0;
        for (int j = 0; j < 4; j++) begin
            x[j]  = a[31-8*j -: 8];
            x2[j] = xtime(x[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
        end
        for (int r = 0; r < 4; r++) begin
            if (inv) begin
                m[0] = x8[r] ^ x4[r] ^ x2[r];
                m[1] = x8[(r+1)&3] ^ x2[(r+1)&3] ^ x[(r+1)&3];
                m[2] = x8[(r+2)&3] ^ x4[(r+2)&3] ^ x[(r+2)&3];
                m[3] = x8[(r+3)&3] ^ x[(r+3)&3];
            end else begin
                m[0] = x2[r];
                m[1] = x2[(r+1)&3] ^ x[(r+1)&3];
                m[2] = x[(r+2)&3];
                m[3] = x[(r+3)&3];
            end
            t[31-8*r -: 8] = m[0] ^ m[1] ^ m[2] ^ m[3];
        end
        return t;
    endfunction

    function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = mix_column(s[127-32*c -: 32], inv);
        end
        return t;
    endfunction

endpackage

>>> hdl/aescbc_front.sv
module aescbc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  aescbc_pkg::t_in_item i_data,
    output logic                 o_item_valid,
    output aescbc_pkg::t_in_item o_item,
    input  logic                 i_item_pop
);

    localparam int DEPTH = aescbc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aescbc_pkg::t_in_item r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wp, r_rp;
    logic [CNT_W-1:0]     r_cnt;
    logic                 push, pop;

    assign o_stall      = (r_cnt == CNT_W'(DEPTH));
    assign push         = i_valid && !o_stall;
    assign pop          = i_item_pop && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/aescbc_keyexp.sv
module aescbc_keyexp #(
    parameter  int ROUND_COUNT = aescbc_pkg::ROUND_COUNT,
    localparam int RND_W       = $clog2(ROUND_COUNT + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aescbc_pkg::t_cfg_wr i_cfg,
    output logic                o_ready,
    input  logic [RND_W-1:0]    i_rd_idx,
    output logic [127:0]        o_rkey
);

    logic [127:0]     r_rk [ROUND_COUNT + 1];
    logic [63:0]      r_key_high, r_key_low;
    logic [127:0]     r_w;
    logic [7:0]       r_rc;
    logic [RND_W-1:0] r_cnt;
    logic             r_busy;
    logic [31:0]      rot, t;
    logic [127:0]     next_w;

    always_comb begin
        rot = {r_w[23:0], r_w[31:24]};
        t   = {aescbc_pkg::sbox_fwd(rot[31:24]), aescbc_pkg::sbox_fwd(rot[23:16]),
               aescbc_pkg::sbox_fwd(rot[15:8]),  aescbc_pkg::sbox_fwd(rot[7:0])}
              ^ {r_rc, 24'h0};
        next_w[127:96] = r_w[127:96] ^ t;
        next_w[95:64]  = r_w[95:64]  ^ next_w[127:96];
        next_w[63:32]  = r_w[63:32]  ^ next_w[95:64];
        next_w[31:0]   = r_w[31:0]   ^ next_w[63:32];
    end

    assign o_ready = !r_busy;
    assign o_rkey  = r_rk[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rk[r_cnt] <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_w        <= '0;
            r_rc       <= 8'h01;
            r_cnt      <= '0;
            r_busy     <= 1'b1;
        end else if (i_cfg.we && i_cfg.idx == aescbc_pkg::CFG_KEY_HIGH) begin
            r_key_high <= i_cfg.data;
            r_w        <= {i_cfg.data, r_key_low};
            r_rc       <= 8'h01;
            r_cnt      <= '0;
            r_busy     <= 1'b1;
        end else if (i_cfg.we && i_cfg.idx == aescbc_pkg::CFG_KEY_LOW) begin
            r_key_low <= i_cfg.data;
            r_w       <= {r_key_high, i_cfg.data};
            r_rc      <= 8'h01;
            r_cnt     <= '0;
            r_busy    <= 1'b1;
        end else if (r_busy) begin
            if (r_cnt == RND_W'(ROUND_COUNT)) begin
                r_busy <= 1'b0;
            end else begin
                r_w   <= next_w;
                r_rc  <= aescbc_pkg::xtime(r_rc);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

>>> hdl/aescbc_core.sv
module aescbc_core #(
    parameter  int ROUND_COUNT = aescbc_pkg::ROUND_COUNT,
    localparam int RND_W       = $clog2(ROUND_COUNT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aescbc_pkg::t_cfg_wr   i_cfg,
    input  logic                  i_item_valid,
    input  aescbc_pkg::t_in_item  i_item,
    output logic                  o_item_pop,
    input  logic                  i_key_ready,
    output logic [RND_W-1:0]      o_key_idx,
    input  logic [127:0]          i_rkey,
    output logic                  o_valid,
    input  logic                  i_stall,
    output aescbc_pkg::t_out_item o_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state           r_state;
    logic [127:0]     r_blk_state, r_chain, r_blk_in;
    logic [63:0]      r_iv_high, r_iv_low;
    logic             r_decrypt;
    logic [RND_W-1:0] r_round;
    logic             r_out_valid;
    aescbc_pkg::t_out_item r_out;

    logic             start, last, out_free;
    logic [127:0]     blk, chain_sel, rnd, res;

    assign blk       = {i_item.block_high, i_item.block_low};
    assign chain_sel = i_item.first_block ? {r_iv_high, r_iv_low} : r_chain;
    assign start     = (r_state == ST_IDLE) && i_item_valid && i_key_ready;
    assign last      = (r_round == RND_W'(ROUND_COUNT));
    assign out_free  = !r_out_valid || !i_stall;
    assign res       = r_decrypt ? (r_blk_state ^ r_chain) : r_blk_state;

    assign o_item_pop = start;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        if (r_state != ST_RUN) begin
            o_key_idx = r_decrypt ? RND_W'(ROUND_COUNT) : '0;
        end else begin
            o_key_idx = r_decrypt ? RND_W'(ROUND_COUNT) - r_round : r_round;
        end
    end

    // one full round per cycle; the final round drops the column mix
    always_comb begin
        if (r_decrypt) begin
            rnd = aescbc_pkg::byte_sub(aescbc_pkg::row_shift(r_blk_state, 1'b1), 1'b1)
                  ^ i_rkey;
            if (!last) begin
                rnd = aescbc_pkg::col_mix(rnd, 1'b1);
            end
        end else begin
            rnd = aescbc_pkg::row_shift(aescbc_pkg::byte_sub(r_blk_state, 1'b0), 1'b0);
            if (!last) begin
                rnd = aescbc_pkg::col_mix(rnd, 1'b0);
            end
            rnd = rnd ^ i_rkey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_high <= '0;
            r_iv_low  <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                aescbc_pkg::CFG_IV_HIGH:      r_iv_high <= i_cfg.data;
                aescbc_pkg::CFG_IV_LOW:       r_iv_low  <= i_cfg.data;
                aescbc_pkg::CFG_DECRYPT_MODE: r_decrypt <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_blk_state <= r_decrypt ? (blk ^ i_rkey)
                                                 : (blk ^ chain_sel ^ i_rkey);
                        r_chain     <= chain_sel;
                        r_blk_in    <= blk;
                        r_round     <= RND_W'(1);
                        r_state     <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_blk_state <= rnd;
                    r_round     <= r_round + 1'b1;
                    if (last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold the finished block until the output register frees
                    if (out_free) begin
                        r_out   <= res;
                        r_chain <= r_decrypt ? r_blk_in : res;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/aes128_cbc_cipher_core.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_data  (block_high, block_low, first_block)
// output    out        o_valid / i_stall    o_data  (result_high, result_low)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// In the round unit a block passes through one load with the first key add,
// ROUND_COUNT rounds at one per cycle, and a write to the output register.
// Chaining makes each block wait for the one before it.
// After reset, and after each key write, the key schedule completes before
// the next block starts; inputs still queue.
// A two-entry input queue takes transfers while a block is in flight; a
// stalled output holds the finished block in the round unit.
module aes128_cbc_cipher_core #(
    parameter  int ROUND_COUNT = aescbc_pkg::ROUND_COUNT,
    localparam int RND_W       = $clog2(ROUND_COUNT + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  aescbc_pkg::t_in_item              i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output aescbc_pkg::t_out_item             o_data,
    input  logic                              i_cfg_we,
    input  logic [aescbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aescbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    aescbc_pkg::t_cfg_wr  cfg;
    aescbc_pkg::t_in_item q_item;
    logic                 q_valid, q_pop, key_ready;
    logic [RND_W-1:0]     key_idx;
    logic [127:0]         rkey;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    aescbc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_item_valid (q_valid),
        .o_item       (q_item),
        .i_item_pop   (q_pop)
    );

    aescbc_keyexp #(.ROUND_COUNT(ROUND_COUNT)) u_keyexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .o_ready     (key_ready),
        .i_rd_idx    (key_idx),
        .o_rkey      (rkey)
    );

    aescbc_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .i_key_ready  (key_ready),
        .o_key_idx    (key_idx),
        .i_rkey       (rkey),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

>>> hdl/aescbc_checker.sv
module aescbc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input aescbc_pkg::t_out_item o_data
);

    // blocks accepted and not yet delivered
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_valid && !o_stall) begin
            n_cnt = n_cnt + 1'b1;
        end
        if (o_valid && !i_stall) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != 3'd0)
        else $error("result without an accepted block");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("more blocks in flight than the design holds");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind aes128_cbc_cipher_core aescbc_checker u_checker (.*);
